/* hw/rtl/assert_macros.svh */
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// expression must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, expr)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* hw/rtl/sm83_pkg.sv */
`timescale 1ns / 1ps

package sm83_pkg;

    // opcode patterns
    localparam logic [7:0] OP_CP_MASK   = 8'hF8;
    localparam logic [7:0] OP_CP_BASE   = 8'hB8;
    localparam logic [7:0] OP_CP_IMM    = 8'hFE;
    localparam logic [7:0] OP_XOR_A     = 8'hAF;
    localparam logic [7:0] OP_CB_BIT7H  = 8'h7C;
    localparam logic [7:0] OP_INC16_MSK = 8'hCF;
    localparam logic [7:0] OP_INC16_VAL = 8'h03;
    localparam logic [7:0] OP_INCDEC_LIM = 8'h40;
    localparam logic [1:0] OP_INCDEC_SEL = 2'b10;

    localparam logic KIND_PLAIN = 1'b0;
    localparam logic KIND_CB    = 1'b1;

    // 3-bit operand code of the instruction set
    typedef enum logic [2:0] {
        RC_B  = 3'd0,
        RC_C  = 3'd1,
        RC_D  = 3'd2,
        RC_E  = 3'd3,
        RC_H  = 3'd4,
        RC_L  = 3'd5,
        RC_HL = 3'd6,
        RC_A  = 3'd7
    } reg_code_t;

    // 16-bit pair select of INC rr
    typedef enum logic [1:0] {
        PAIR_BC = 2'd0,
        PAIR_DE = 2'd1,
        PAIR_HL = 2'd2,
        PAIR_SP = 2'd3
    } pair_sel_t;

    typedef enum logic [2:0] {
        CLS_NONE,
        CLS_BIT,
        CLS_CP,
        CLS_XOR,
        CLS_INCDEC,
        CLS_INC16
    } op_class_t;

    typedef struct packed {
        logic z;
        logic n;
        logic h;
        logic c;
    } flags_t;

endpackage

/* hw/rtl/sm83_inc_dec_compare_unit.sv */
`timescale 1ns / 1ps
// a command passes the input register and then the result register
// throughput: one instruction per cycle when not stalled; one register file update per edge
// a stalled result holds the command stage, which then stalls the command channel
// reset: registers A..L, SP and flags cleared, both stages emptied

`include "assert_macros.svh"

module sm83_inc_dec_compare_unit
    import sm83_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cmd_valid,
    output logic        cmd_stall,
    input  logic        kind,
    input  logic [7:0]  opcode,
    input  logic [7:0]  immediate,
    input  logic [7:0]  mem_operand,

    output logic        res_valid,
    input  logic        res_stall,
    output logic        handled,
    output logic        flag_zero,
    output logic        flag_subtract,
    output logic        flag_half,
    output logic        flag_carry,
    output logic [7:0]  result_byte,
    output logic [15:0] pair_result,
    output logic        write_memory,
    output logic [15:0] memory_address
);

    // command stage
    logic       cmd_valid_reg;
    logic       kind_reg;
    logic [7:0] opcode_reg;
    logic [7:0] immediate_reg;
    logic [7:0] mem_operand_reg;

    // architectural state
    logic [7:0]  a_reg, b_reg, c_reg, d_reg, e_reg, h_reg, l_reg;
    logic [7:0]  a_next, b_next, c_next, d_next, e_next, h_next, l_next;
    logic [15:0] sp_reg, sp_next;
    flags_t      flags_reg, flags_next;

    // result stage
    logic        res_valid_reg;
    logic        handled_reg, handled_next;
    flags_t      res_flags_reg;
    logic [7:0]  result_byte_reg, result_byte_next;
    logic [15:0] pair_result_reg, pair_result_next;
    logic        write_memory_reg, write_memory_next;
    logic [15:0] memory_address_reg, memory_address_next;

    logic        res_free;
    logic        fire;
    logic        cmd_take;
    op_class_t   op_class;

    logic [7:0]  cp_operand;
    logic [7:0]  old_byte;
    logic [7:0]  new_byte;
    logic [15:0] hl_value;
    logic [15:0] pair_sum;
    reg_code_t   cp_code;
    reg_code_t   id_code;
    pair_sel_t   pair_sel;
    logic        is_dec;

    function automatic logic [7:0] reg_pick(
        input reg_code_t  code,
        input logic [7:0] ra, rb, rc, rd, re, rh, rl
    );
        logic [7:0] v;
        begin
            case (code)
                RC_B:    v = rb;
                RC_C:    v = rc;
                RC_D:    v = rd;
                RC_E:    v = re;
                RC_H:    v = rh;
                RC_L:    v = rl;
                RC_A:    v = ra;
                default: v = ra;
            endcase
            return v;
        end
    endfunction

    assign res_free  = !res_valid_reg || !res_stall;
    assign fire      = cmd_valid_reg && res_free;
    assign cmd_stall = cmd_valid_reg && !res_free;
    assign cmd_take  = cmd_valid && !cmd_stall;

    assign hl_value = {h_reg, l_reg};
    assign cp_code  = reg_code_t'(opcode_reg[2:0]);
    assign id_code  = reg_code_t'(opcode_reg[5:3]);
    assign pair_sel = pair_sel_t'(opcode_reg[5:4]);
    assign is_dec   = opcode_reg[0];

    // instruction decode
    always_comb
    begin
        op_class = CLS_NONE;
        if (kind_reg == KIND_CB)
        begin
            if (opcode_reg == OP_CB_BIT7H)
                op_class = CLS_BIT;
        end
        else if ((opcode_reg & OP_CP_MASK) == OP_CP_BASE || opcode_reg == OP_CP_IMM)
            op_class = CLS_CP;
        else if (opcode_reg == OP_XOR_A)
            op_class = CLS_XOR;
        else if (opcode_reg < OP_INCDEC_LIM && opcode_reg[2:1] == OP_INCDEC_SEL)
            op_class = CLS_INCDEC;
        else if ((opcode_reg & OP_INC16_MSK) == OP_INC16_VAL)
            op_class = CLS_INC16;
    end

    // operands
    always_comb
    begin
        if (opcode_reg == OP_CP_IMM)
            cp_operand = immediate_reg;
        else if (cp_code == RC_HL)
            cp_operand = mem_operand_reg;
        else
            cp_operand = reg_pick(cp_code, a_reg, b_reg, c_reg, d_reg, e_reg, h_reg, l_reg);

        if (id_code == RC_HL)
            old_byte = mem_operand_reg;
        else
            old_byte = reg_pick(id_code, a_reg, b_reg, c_reg, d_reg, e_reg, h_reg, l_reg);

        new_byte = is_dec ? old_byte - 8'd1 : old_byte + 8'd1;

        case (pair_sel)
            PAIR_BC: pair_sum = {b_reg, c_reg} + 16'd1;
            PAIR_DE: pair_sum = {d_reg, e_reg} + 16'd1;
            PAIR_HL: pair_sum = hl_value + 16'd1;
            PAIR_SP: pair_sum = sp_reg + 16'd1;
            default: pair_sum = sp_reg + 16'd1;
        endcase
    end

    // execute
    always_comb
    begin
        a_next = a_reg;
        b_next = b_reg;
        c_next = c_reg;
        d_next = d_reg;
        e_next = e_reg;
        h_next = h_reg;
        l_next = l_reg;
        sp_next = sp_reg;
        flags_next = flags_reg;
        handled_next = 1'b1;
        result_byte_next = 8'd0;
        pair_result_next = 16'd0;
        write_memory_next = 1'b0;
        memory_address_next = 16'd0;

        case (op_class)
            CLS_BIT:
            begin
                flags_next.z = !h_reg[7];
            end
            CLS_CP:
            begin
                flags_next.z = (a_reg == cp_operand);
                flags_next.n = 1'b1;
                flags_next.h = (a_reg[3:0] < cp_operand[3:0]);
                flags_next.c = (a_reg < cp_operand);
                if (opcode_reg != OP_CP_IMM && cp_code == RC_HL)
                    memory_address_next = hl_value;
            end
            CLS_XOR:
            begin
                a_next = 8'd0;
                flags_next = '{z: 1'b1, n: 1'b0, h: 1'b0, c: 1'b0};
            end
            CLS_INCDEC:
            begin
                result_byte_next = new_byte;
                flags_next.z = (new_byte == 8'd0);
                flags_next.n = is_dec;
                flags_next.h = is_dec ? (old_byte[3:0] == 4'h0) : (old_byte[3:0] == 4'hF);
                case (id_code)
                    RC_B:    b_next = new_byte;
                    RC_C:    c_next = new_byte;
                    RC_D:    d_next = new_byte;
                    RC_E:    e_next = new_byte;
                    RC_H:    h_next = new_byte;
                    RC_L:    l_next = new_byte;
                    RC_A:    a_next = new_byte;
                    default:
                    begin
                        // memory target goes out as a write request
                        write_memory_next = 1'b1;
                        memory_address_next = hl_value;
                    end
                endcase
            end
            CLS_INC16:
            begin
                pair_result_next = pair_sum;
                case (pair_sel)
                    PAIR_BC: {b_next, c_next} = pair_sum;
                    PAIR_DE: {d_next, e_next} = pair_sum;
                    PAIR_HL: {h_next, l_next} = pair_sum;
                    default: sp_next = pair_sum;
                endcase
            end
            default:
            begin
                handled_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
            a_reg <= 8'd0;
            b_reg <= 8'd0;
            c_reg <= 8'd0;
            d_reg <= 8'd0;
            e_reg <= 8'd0;
            h_reg <= 8'd0;
            l_reg <= 8'd0;
            sp_reg <= 16'd0;
            flags_reg <= '0;
        end
        else
        begin
            if (cmd_take)
                cmd_valid_reg <= 1'b1;
            else if (fire)
                cmd_valid_reg <= 1'b0;

            if (fire)
                res_valid_reg <= 1'b1;
            else if (!res_stall)
                res_valid_reg <= 1'b0;

            if (fire)
            begin
                a_reg <= a_next;
                b_reg <= b_next;
                c_reg <= c_next;
                d_reg <= d_next;
                e_reg <= e_next;
                h_reg <= h_next;
                l_reg <= l_next;
                sp_reg <= sp_next;
                flags_reg <= flags_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            kind_reg <= kind;
            opcode_reg <= opcode;
            immediate_reg <= immediate;
            mem_operand_reg <= mem_operand;
        end
        if (fire)
        begin
            handled_reg <= handled_next;
            res_flags_reg <= flags_next;
            result_byte_reg <= result_byte_next;
            pair_result_reg <= pair_result_next;
            write_memory_reg <= write_memory_next;
            memory_address_reg <= memory_address_next;
        end
    end

    assign res_valid      = res_valid_reg;
    assign handled        = handled_reg;
    assign flag_zero      = res_flags_reg.z;
    assign flag_subtract  = res_flags_reg.n;
    assign flag_half      = res_flags_reg.h;
    assign flag_carry     = res_flags_reg.c;
    assign result_byte    = result_byte_reg;
    assign pair_result    = pair_result_reg;
    assign write_memory   = write_memory_reg;
    assign memory_address = memory_address_reg;

    // every executed transaction reaches the result stage
    `ASSERT_NEXT(a_fire_fills_result, clk, rst_n, fire, res_valid_reg)
    // the command stage never accepts over a held command
    `ASSERT_ALWAYS(a_no_overwrite, clk, rst_n, !(cmd_take && cmd_valid_reg && !fire))
    // a memory write request only comes from an executed instruction
    `ASSERT_ALWAYS(a_write_handled, clk, rst_n, !(res_valid_reg && write_memory_reg) || handled_reg)
    // an unsupported opcode gives empty data fields
    `ASSERT_ALWAYS(a_unhandled_clean, clk, rst_n,
        !(res_valid_reg && !handled_reg) ||
        (result_byte_reg == 8'd0 && pair_result_reg == 16'd0 && memory_address_reg == 16'd0))
    // xor a leaves the accumulator cleared
    `ASSERT_NEXT(a_xor_clears_a, clk, rst_n, fire && op_class == CLS_XOR, a_reg == 8'd0)

endmodule
